### src/assert_macros.svh
// assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define TRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent implies consequent in the same cycle
`define TRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/trp_pkg.sv
`timescale 1ns / 1ps

package trp_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_NAME   = 3'd1;
  localparam logic [2:0] ST_NO_MODE   = 3'd2;
  localparam logic [2:0] ST_BAD_MODE  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_BLK_RANGE = 3'd5;
  localparam logic [2:0] ST_WIN_RANGE = 3'd6;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic MODE_NETASCII = 1'b0;
  localparam logic MODE_OCTET    = 1'b1;

  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  localparam logic [55:0] BLK_WORD = "blksize";
  localparam logic [79:0] WIN_WORD = "windowsize";

  localparam logic [16:0] SAT_LIMIT = 17'd65536;
  localparam logic [16:0] BLK_MIN   = 17'd8;
  localparam logic [16:0] BLK_MAX   = 17'd65464;
  localparam logic [16:0] WIN_MIN   = 17'd1;
  localparam logic [16:0] WIN_MAX   = 17'd65535;

  // value flag bits
  localparam int FLG_KIND = 0;
  localparam int FLG_NEG  = 1;
  localparam int FLG_LEAD = 2;
  localparam int FLG_STOP = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } byte_pl_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic [2:0]  status;
    logic        transfer_mode;
    logic        blksize_asked;
    logic [15:0] block_size;
    logic        window_asked;
    logic [15:0] window_size;
  } result_pl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } stage_t;

  typedef struct packed {
    logic [16:0] fed_acc;
    logic [3:0]  fed_flags;
    logic        cur_ok;
    logic [15:0] cur_val;
    logic        fed_ok;
    logic [15:0] fed_val;
  } val_res_t;

endpackage

### src/trp_byte_if.sv
`timescale 1ns / 1ps

interface trp_byte_if
  import trp_pkg::*;
();
  logic     valid;
  logic     ready;
  byte_pl_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/trp_result_if.sv
`timescale 1ns / 1ps

interface trp_result_if
  import trp_pkg::*;
();
  logic       valid;
  logic       ready;
  result_pl_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/trp_value_unit.sv
`timescale 1ns / 1ps

module trp_value_unit
  import trp_pkg::*;
(
  input  logic [7:0]  data_byte,
  input  logic [16:0] acc,
  input  logic [3:0]  flags,
  output val_res_t    res
);

  logic        digit;
  logic        space;
  logic [19:0] prod;
  logic [16:0] sat;

  function automatic logic range_ok(input logic [16:0] a, input logic [3:0] f);
    logic [16:0] v;
    begin
      v = f[FLG_NEG] ? '0 : a;
      if (f[FLG_KIND]) range_ok = (v >= WIN_MIN) && (v <= WIN_MAX);
      else range_ok = (v >= BLK_MIN) && (v <= BLK_MAX);
    end
  endfunction

  function automatic logic [15:0] range_val(input logic [16:0] a, input logic [3:0] f);
    begin
      range_val = f[FLG_NEG] ? 16'd0 : a[15:0];
    end
  endfunction

  always_comb begin
    digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    space = (data_byte == CHAR_SPACE) || ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
    prod  = {acc, 3'b000} + {2'b00, acc, 1'b0} + {16'd0, data_byte[3:0]};
    sat   = (prod > {3'b000, SAT_LIMIT}) ? SAT_LIMIT : prod[16:0];

    res.fed_acc   = acc;
    res.fed_flags = flags;
    if (!flags[FLG_STOP] && (flags[FLG_LEAD] || !space)) begin
      res.fed_flags[FLG_LEAD] = 1'b1;
      if (!flags[FLG_LEAD] && ((data_byte == CHAR_PLUS) || (data_byte == CHAR_MINUS))) begin
        if (data_byte == CHAR_MINUS) res.fed_flags[FLG_NEG] = 1'b1;
      end else if (digit) begin
        res.fed_acc = sat;
      end else begin
        res.fed_flags[FLG_STOP] = 1'b1;
      end
    end

    res.cur_ok  = range_ok(acc, flags);
    res.cur_val = range_val(acc, flags);
    res.fed_ok  = range_ok(res.fed_acc, res.fed_flags);
    res.fed_val = range_val(res.fed_acc, res.fed_flags);
  end

endmodule

### src/trp_in_stage.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trp_in_stage
  import trp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  trp_byte_if.sink   packet,
  input  logic       take,
  output stage_t     stg
);

  logic accept;

  assign packet.ready = !stg.valid || take;
  assign accept       = packet.valid && packet.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg.valid <= 1'b0;
    end else if (accept) begin
      stg.valid <= 1'b1;
    end else if (take) begin
      stg.valid <= 1'b0;
    end
    if (accept) begin
      stg.data_byte     <= packet.payload.data_byte;
      stg.end_of_packet <= packet.payload.end_of_packet;
    end
  end

  `TRP_ASSERT_NXT(a_stage_loads, accept, stg.valid, "accepted transaction not staged")
  `TRP_ASSERT_NXT(a_stage_holds, stg.valid && !take,
                  stg.valid && $stable(stg.data_byte), "staged byte lost")

endmodule

### src/trp_parse_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trp_parse_core
  import trp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stage_t      stg,
  output logic        take,
  trp_result_if.source result
);

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_NAME,
    PH_MODE,
    PH_OPTION,
    PH_VALUE,
    PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic        opcode_count, opcode_next;
  logic [79:0] sfx, sfx_next;
  logic [16:0] value_accumulator, acc_next;
  logic [3:0]  value_flags, flags_next;
  logic [2:0]  latched_status, status_next;
  logic        mode_reg, mode_next;
  logic [16:0] blk_reg, blk_next;
  logic [16:0] win_reg, win_next;
  logic        emit;
  logic        err;
  logic [2:0]  err_code;
  logic        out_free;
  logic        proc;
  logic        eop;
  logic [7:0]  b;
  logic [2:0]  range_code;
  result_pl_t  res_next;
  val_res_t    vr;

  assign b        = stg.data_byte;
  assign eop      = stg.end_of_packet;
  assign out_free = !result.valid || result.ready;
  assign take     = stg.valid && out_free;
  assign proc     = take;

  trp_value_unit u_value (
    .data_byte (b),
    .acc       (value_accumulator),
    .flags     (value_flags),
    .res       (vr)
  );

  always_comb begin
    phase_next  = phase;
    opcode_next = opcode_count;
    acc_next    = value_accumulator;
    flags_next  = value_flags;
    status_next = latched_status;
    mode_next   = mode_reg;
    blk_next    = blk_reg;
    win_next    = win_reg;
    emit        = 1'b0;
    err         = 1'b0;
    err_code    = ST_OK;
    range_code  = value_flags[FLG_KIND] ? ST_WIN_RANGE : ST_BLK_RANGE;

    unique case (phase)
      PH_OPCODE: begin
        if (eop) begin
          err = 1'b1; err_code = ST_NO_NAME;
        end else begin
          if (opcode_count) phase_next = PH_NAME;
          opcode_next = 1'b1;
        end
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          if (eop) begin
            err = 1'b1; err_code = ST_NO_MODE;
          end else begin
            phase_next = PH_MODE;
          end
        end else if (eop) begin
          err = 1'b1; err_code = ST_NO_NAME;
        end else begin
          emit = 1'b1;
        end
      end
      PH_MODE: begin
        if (b == 8'd0) begin
          if (sfx[7:0] == CHAR_I) begin
            mode_next = MODE_NETASCII; phase_next = PH_OPTION;
          end else if (sfx[7:0] == CHAR_T) begin
            mode_next = MODE_OCTET; phase_next = PH_OPTION;
          end else begin
            err = 1'b1; err_code = ST_BAD_MODE;
          end
        end else if (eop) begin
          err = 1'b1; err_code = ST_NO_MODE;
        end
      end
      PH_OPTION: begin
        if (b == 8'd0) begin
          if (sfx[55:0] == BLK_WORD) begin
            blk_next[16] = 1'b1;
            if (eop) begin
              err = 1'b1; err_code = ST_TRUNC;
            end else begin
              phase_next = PH_VALUE; acc_next = '0; flags_next = 4'b0000;
            end
          end else if (sfx == WIN_WORD) begin
            win_next[16] = 1'b1;
            if (eop) begin
              err = 1'b1; err_code = ST_TRUNC;
            end else begin
              phase_next = PH_VALUE; acc_next = '0; flags_next = 4'b0001;
            end
          end
        end else if (eop) begin
          err = 1'b1; err_code = ST_TRUNC;
        end
      end
      PH_VALUE: begin
        if (b == 8'd0) begin
          if (vr.cur_ok) begin
            if (value_flags[FLG_KIND]) win_next = {1'b1, vr.cur_val};
            else blk_next = {1'b1, vr.cur_val};
            phase_next = PH_OPTION;
          end else begin
            err = 1'b1; err_code = range_code;
          end
        end else begin
          acc_next   = vr.fed_acc;
          flags_next = vr.fed_flags;
          if (eop) begin
            if (vr.fed_ok) begin
              if (value_flags[FLG_KIND]) win_next = {1'b1, vr.fed_val};
              else blk_next = {1'b1, vr.fed_val};
              err_code = ST_TRUNC;
            end else begin
              err_code = range_code;
            end
            err = 1'b1;
          end
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    if (err) begin
      if (latched_status == ST_OK) status_next = err_code;
      phase_next = PH_SKIP;
    end

    res_next = '0;
    if (emit) begin
      res_next.kind      = KIND_NAME;
      res_next.name_byte = b;
    end else begin
      res_next.kind          = KIND_VERDICT;
      res_next.status        = status_next;
      res_next.transfer_mode = (status_next == ST_OK) ? mode_next : MODE_NETASCII;
      res_next.blksize_asked = blk_next[16];
      res_next.block_size    = blk_next[15:0];
      res_next.window_asked  = win_next[16];
      res_next.window_size   = win_next[15:0];
    end

    sfx_next = {sfx[71:0], b};
    if (eop) begin
      phase_next  = PH_OPCODE;
      opcode_next = 1'b0;
      sfx_next    = '0;
      acc_next    = '0;
      flags_next  = '0;
      status_next = ST_OK;
      mode_next   = MODE_NETASCII;
      blk_next    = '0;
      win_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_OPCODE;
      opcode_count      <= 1'b0;
      sfx               <= '0;
      value_accumulator <= '0;
      value_flags       <= '0;
      latched_status    <= ST_OK;
      mode_reg          <= MODE_NETASCII;
      blk_reg           <= '0;
      win_reg           <= '0;
      result.valid      <= 1'b0;
    end else begin
      if (proc) begin
        phase             <= phase_next;
        opcode_count      <= opcode_next;
        sfx               <= sfx_next;
        value_accumulator <= acc_next;
        value_flags       <= flags_next;
        latched_status    <= status_next;
        mode_reg          <= mode_next;
        blk_reg           <= blk_next;
        win_reg           <= win_next;
      end
      if (out_free) result.valid <= proc && (emit || eop);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) result.payload <= res_next;
  end

  `TRP_ASSERT_NXT(a_eop_clears, proc && eop,
                  phase == PH_OPCODE && latched_status == ST_OK && !opcode_count,
                  "packet state not cleared after verdict")
  `TRP_ASSERT_NXT(a_status_sticky, latched_status != ST_OK && !(proc && eop),
                  latched_status == $past(latched_status), "latched error changed")
  `TRP_ASSERT(a_acc_bound, value_accumulator <= SAT_LIMIT, "value above saturation")
  `TRP_ASSERT_IMP(a_mode_on_error,
                  result.valid && result.payload.kind == KIND_VERDICT &&
                  result.payload.status != ST_OK,
                  result.payload.transfer_mode == MODE_NETASCII, "mode set on error verdict")

endmodule

### src/tftp_request_parser.sv
`timescale 1ns / 1ps

// request packet parser
// packet: one request byte per transaction, opcode bytes first, with
//   end_of_packet set on the last byte
// result: one transaction per filename byte (kind 0), and one verdict
//   (kind 1) for the byte marked end_of_packet; other bytes give nothing
// the verdict carries the first error seen, the mode and the latest
//   accepted blksize and windowsize values
// path: an accepted byte goes into the input register, then through
//   the parse logic into the result register
// throughput: one byte per cycle while the result side takes transactions;
//   the per-byte parse state update sets that figure
// a stalled result holds in the result register; the input register takes
//   a byte only while empty, and packet.ready stays low until the result is taken
// reset clears the valid flags of both registers and all parse state; the
//   block is ready for a new packet in the first cycle after reset
module tftp_request_parser
  import trp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  trp_byte_if.sink      packet,
  trp_result_if.source  result
);

  stage_t stg;
  logic   take;

  trp_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .packet (packet),
    .take   (take),
    .stg    (stg)
  );

  trp_parse_core u_core (
    .clk    (clk),
    .rst    (rst),
    .stg    (stg),
    .take   (take),
    .result (result)
  );

endmodule

### test/tb_tftp_request_parser.sv
`timescale 1ns / 1ps

module tb_tftp_request_parser;
  import trp_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BYTES = 1950;

  typedef enum logic [2:0] {
    P_OPCODE,
    P_NAME,
    P_MODE,
    P_OPTION,
    P_VALUE,
    P_SKIP
  } parse_phase_t;

  logic clk;
  logic rst;

  trp_byte_if packet_if ();
  trp_result_if result_if ();

  tftp_request_parser uut (
    .clk    (clk),
    .rst    (rst),
    .packet (packet_if),
    .result (result_if)
  );

  // parser state mirrored for prediction
  parse_phase_t rq_phase;
  logic         rq_opcode_seen;
  logic [7:0]   rq_prev;
  logic [79:0]  rq_tail;
  logic [16:0]  rq_acc;
  logic [3:0]   rq_flags;
  logic [2:0]   rq_status;
  logic         rq_mode;
  logic [16:0]  rq_blk;
  logic [16:0]  rq_win;

  result_pl_t  name_and_verdict_q[$];
  logic [7:0]  pkt_bytes[$];
  int unsigned bytes_sent;
  int unsigned err_count;
  int unsigned quiet_cycles;
  int          hold_left;
  logic        hold_start;
  bit          src_gaps;
  bit          sink_gaps;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_request_state();
    rq_phase = P_OPCODE;
    rq_opcode_seen = 1'b0;
    rq_prev = '0;
    rq_tail = '0;
    rq_acc = '0;
    rq_flags = '0;
    rq_status = ST_OK;
    rq_mode = MODE_NETASCII;
    rq_blk = '0;
    rq_win = '0;
  endfunction

  function automatic void latch_error(logic [2:0] code);
    if (rq_status == ST_OK) rq_status = code;
    rq_phase = P_SKIP;
  endfunction

  function automatic void feed_value_char(logic [7:0] b);
    logic [31:0] grown;
    if (rq_flags[FLG_STOP]) return;
    if (!rq_flags[FLG_LEAD]) begin
      if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)) return;
      rq_flags[FLG_LEAD] = 1'b1;
      if (b == CHAR_PLUS || b == CHAR_MINUS) begin
        if (b == CHAR_MINUS) rq_flags[FLG_NEG] = 1'b1;
        return;
      end
    end
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      grown = 32'(rq_acc) * 32'd10 + 32'(b - CHAR_ZERO);
      rq_acc = (grown > 32'(SAT_LIMIT)) ? SAT_LIMIT : grown[16:0];
    end else begin
      rq_flags[FLG_STOP] = 1'b1;
    end
  endfunction

  function automatic bit accept_value();
    logic [16:0] v;
    v = rq_flags[FLG_NEG] ? 17'd0 : rq_acc;
    if (rq_flags[FLG_KIND]) begin
      if (v < WIN_MIN || v > WIN_MAX) begin
        latch_error(ST_WIN_RANGE);
        return 1'b0;
      end
      rq_win = {1'b1, v[15:0]};
    end else begin
      if (v < BLK_MIN || v > BLK_MAX) begin
        latch_error(ST_BLK_RANGE);
        return 1'b0;
      end
      rq_blk = {1'b1, v[15:0]};
    end
    return 1'b1;
  endfunction

  function automatic void start_value(logic for_window);
    rq_phase = P_VALUE;
    rq_acc = '0;
    rq_flags = '0;
    rq_flags[FLG_KIND] = for_window;
  endfunction

  function automatic void parse_request_byte(logic [7:0] b, logic eop);
    result_pl_t r;
    r = '0;
    case (rq_phase)
      P_OPCODE: begin
        if (eop) latch_error(ST_NO_NAME);
        else begin
          if (rq_opcode_seen) rq_phase = P_NAME;
          rq_opcode_seen = 1'b1;
        end
      end
      P_NAME: begin
        if (b == 8'h00) begin
          if (eop) latch_error(ST_NO_MODE);
          else rq_phase = P_MODE;
        end else if (eop) begin
          latch_error(ST_NO_NAME);
        end else begin
          r.kind = KIND_NAME;
          r.name_byte = b;
          name_and_verdict_q = {name_and_verdict_q, r};
        end
      end
      P_MODE: begin
        if (b == 8'h00) begin
          if (rq_prev == CHAR_I) begin
            rq_mode = MODE_NETASCII;
            rq_phase = P_OPTION;
          end else if (rq_prev == CHAR_T) begin
            rq_mode = MODE_OCTET;
            rq_phase = P_OPTION;
          end else begin
            latch_error(ST_BAD_MODE);
          end
        end else if (eop) begin
          latch_error(ST_NO_MODE);
        end
      end
      P_OPTION: begin
        if (b == 8'h00) begin
          if (rq_tail[55:0] == BLK_WORD) begin
            rq_blk[16] = 1'b1;
            if (eop) latch_error(ST_TRUNC);
            else start_value(1'b0);
          end else if (rq_tail == WIN_WORD) begin
            rq_win[16] = 1'b1;
            if (eop) latch_error(ST_TRUNC);
            else start_value(1'b1);
          end
        end else if (eop) begin
          latch_error(ST_TRUNC);
        end
      end
      P_VALUE: begin
        if (b == 8'h00) begin
          if (accept_value()) rq_phase = P_OPTION;
        end else begin
          feed_value_char(b);
          if (eop && accept_value()) latch_error(ST_TRUNC);
        end
      end
      default: ;
    endcase

    if (eop) begin
      r = '0;
      r.kind = KIND_VERDICT;
      r.status = rq_status;
      r.transfer_mode = (rq_status == ST_OK) ? rq_mode : MODE_NETASCII;
      r.blksize_asked = rq_blk[16];
      r.block_size = rq_blk[15:0];
      r.window_asked = rq_win[16];
      r.window_size = rq_win[15:0];
      name_and_verdict_q = {name_and_verdict_q, r};
      clear_request_state();
    end else begin
      rq_prev = b;
      rq_tail = {rq_tail[71:0], b};
    end
  endfunction

  task automatic note_error(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic check_result(input result_pl_t got);
    result_pl_t want;
    if (name_and_verdict_q.size() == 0) begin
      note_error("result with nothing expected, kind", got.kind, -1);
      return;
    end
    want = name_and_verdict_q.pop_front();
    if (got.kind !== want.kind) note_error("kind", got.kind, want.kind);
    if (got.name_byte !== want.name_byte) note_error("name_byte", got.name_byte, want.name_byte);
    if (got.status !== want.status) note_error("status", got.status, want.status);
    if (got.transfer_mode !== want.transfer_mode)
      note_error("transfer_mode", got.transfer_mode, want.transfer_mode);
    if (got.blksize_asked !== want.blksize_asked)
      note_error("blksize_asked", got.blksize_asked, want.blksize_asked);
    if (got.block_size !== want.block_size)
      note_error("block_size", got.block_size, want.block_size);
    if (got.window_asked !== want.window_asked)
      note_error("window_asked", got.window_asked, want.window_asked);
    if (got.window_size !== want.window_size)
      note_error("window_size", got.window_size, want.window_size);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eop);
    while (src_gaps && $urandom_range(99) < 10) begin
      packet_if.valid <= 1'b0;
      @(posedge clk);
    end
    packet_if.valid <= 1'b1;
    packet_if.payload <= {b, eop};
    do @(posedge clk); while (packet_if.ready !== 1'b1);
    parse_request_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    pkt_bytes = {pkt_bytes, b};
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes = {pkt_bytes, s[i]};
  endtask

  task automatic put_token(input string s);
    put_str(s);
    put_byte(8'h00);
  endtask

  task automatic put_opcode();
    put_byte(8'h00);
    put_byte(8'h01);
  endtask

  task automatic start_request(input string mode);
    put_opcode();
    put_token("f");
    put_token(mode);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  function automatic string value_text(bit for_window);
    string s;
    int unsigned n;
    int unsigned pick;
    s = "";
    pick = $urandom_range(99);
    if (pick < 55) n = for_window ? $urandom_range(65535, 1) : $urandom_range(65464, 8);
    else if (pick < 70) n = $urandom_range(20);
    else begin
      case ($urandom_range(7))
        0: n = 0;
        1: n = 1;
        2: n = 7;
        3: n = 8;
        4: n = 65464;
        5: n = 65465;
        6: n = 65535;
        default: n = 65536;
      endcase
    end
    if ($urandom_range(9) == 0) s = {s, " "};
    if ($urandom_range(9) == 0) s = {s, "\t"};
    case ($urandom_range(19))
      0: s = {s, "-"};
      1: s = {s, "+"};
      default: ;
    endcase
    if ($urandom_range(19) == 0) s = {s, "123456789012"};
    else s = {s, $sformatf("%0d", n)};
    if ($urandom_range(9) == 0) s = {s, "k"};
    if ($urandom_range(29) == 0) s = "";
    return s;
  endfunction

  task automatic build_random_request();
    int unsigned shape;
    int unsigned len;
    int unsigned keep;
    shape = $urandom_range(99);
    if (shape < 5) begin
      len = $urandom_range(24, 1);
      repeat (len) put_byte(8'($urandom_range(255)));
    end else begin
      put_byte(8'($urandom_range(255)));
      put_byte(8'($urandom_range(255)));
      len = $urandom_range(10, 1);
      repeat (len) begin
        if ($urandom_range(9) < 7) put_byte(8'($urandom_range(8'h7a, 8'h61)));
        else put_byte(8'($urandom_range(255, 1)));
      end
      put_byte(8'h00);
      case ($urandom_range(9))
        0, 1, 2, 3: put_token("netascii");
        4, 5, 6: put_token("octet");
        7: put_token("mail");
        8: begin
          len = $urandom_range(3, 1);
          repeat (len) put_byte(8'($urandom_range(255, 1)));
          put_byte(8'h00);
        end
        default: put_byte(8'h00);
      endcase
      len = $urandom_range(3);
      repeat (len) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            put_token("blksize");
            put_token(value_text(1'b0));
          end
          4, 5, 6: begin
            put_token("windowsize");
            put_token(value_text(1'b1));
          end
          7: begin
            if ($urandom_range(1)) put_token("tsize");
            else put_token("timeout");
            put_token("512");
          end
          8: begin
            put_token("xwindowsize");
            put_token(value_text(1'b1));
          end
          default: put_token("blksizes");
        endcase
      end
      if (shape < 20) begin
        keep = $urandom_range(pkt_bytes.size(), 1);
        while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
      end
    end
    send_packet();
  endtask

  task automatic test_name_errors();
    put_byte(8'hff);
    send_packet();
    put_opcode();
    put_str("ab");
    send_packet();
    put_opcode();
    put_byte(8'hff);
    put_byte(8'h80);
    put_byte(8'h00);
    send_packet();
  endtask

  task automatic test_mode();
    put_opcode();
    put_token("f");
    put_str("octe");
    send_packet();
    start_request("");
    send_packet();
    start_request("netascii");
    send_packet();
    start_request("octet");
    send_packet();
    start_request("mail");
    put_token("tail");
    send_packet();
  endtask

  task automatic test_options();
    start_request("octet");
    put_token("blksize");
    put_token("1024");
    put_token("windowsize");
    put_token("16");
    send_packet();
    start_request("octet");
    put_token("blksize");
    send_packet();
    start_request("netascii");
    put_token("windowsize");
    send_packet();
    start_request("octet");
    put_token("blksize");
    put_str("512");
    send_packet();
    start_request("octet");
    put_token("blksize");
    put_str("5");
    send_packet();
    start_request("octet");
    put_token("xblksize");
    put_token("8");
    put_token("blk");
    put_token("size");
    put_token("blksizex");
    put_token("windowsize");
    put_token("65535");
    send_packet();
  endtask

  task automatic test_values();
    start_request("octet");
    put_token("windowsize");
    put_token("-5");
    send_packet();
    start_request("octet");
    put_token("blksize");
    put_token("");
    send_packet();
    start_request("netascii");
    put_token("blksize");
    put_token(" \t+65464x");
    send_packet();
    start_request("octet");
    put_token("windowsize");
    put_token("99999999");
    send_packet();
    start_request("octet");
    put_token("blksize");
    put_token("65465");
    send_packet();
    start_request("octet");
    put_token("windowsize");
    put_token("0");
    send_packet();
    start_request("octet");
    put_token("blksize");
    put_token("7");
    put_token("windowsize");
    put_token("8");
    send_packet();
    start_request("octet");
    put_token("blksize");
    put_token("100");
    put_token("blksize");
    put_token("200");
    put_token("windowsize");
    put_token(" - 5");
    send_packet();
  endtask

  // result side held off while the sender keeps offering bytes
  task automatic test_result_stall();
    src_gaps = 0;
    packet_if.valid <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    put_opcode();
    for (int i = 0; i < 24; i++) put_byte(8'h61 + 8'(i));
    put_byte(8'h00);
    put_token("octet");
    send_packet();
    src_gaps = 1;
  endtask

  task automatic test_random_requests();
    while (bytes_sent < 900) build_random_request();
    src_gaps = 0;
    sink_gaps = 0;
    while (bytes_sent < 1300) build_random_request();
    src_gaps = 1;
    sink_gaps = 1;
    while (bytes_sent < RANDOM_BYTES) build_random_request();
  endtask

  initial begin
    result_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_start) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= !(sink_gaps && $urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) check_result(result_if.payload);
      if ((result_if.valid === 1'b1 && result_if.ready === 1'b1) ||
          (packet_if.valid === 1'b1 && packet_if.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_tftp_request_parser: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    packet_if.valid <= 1'b0;
    packet_if.payload <= '0;
    hold_start <= 1'b0;
    src_gaps = 1;
    sink_gaps = 1;
    bytes_sent = 0;
    err_count = 0;
    quiet_cycles = 0;
    clear_request_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_name_errors();
    test_mode();
    test_options();
    test_values();
    test_result_stall();
    test_random_requests();

    packet_if.valid <= 1'b0;
    while (name_and_verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_tftp_request_parser: done, clean");
    end else begin
      $display("tb_tftp_request_parser: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/trp_pkg.sv
src/trp_byte_if.sv
src/trp_result_if.sv
src/trp_value_unit.sv
src/trp_in_stage.sv
src/trp_parse_core.sv
src/tftp_request_parser.sv
test/tb_tftp_request_parser.sv
